@@ sv/qwt_pkg.sv @@
package qwt_pkg;

  // Special characters
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNul    = 8'h00;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_BLANK = 2'd1,
    KIND_SEMI  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  // One queued command from the classifier to the emitter
  typedef struct packed {
    logic [7:0] data;     // word byte, zero for end markers
    kind_e      kind;
    logic       esc_pair; // emit a kept backslash ahead of data
  } qwt_cmd_t;

  // Whitespace: space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

@@ sv/qwt_front.sv @@
module qwt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output qwt_pkg::qwt_cmd_t cmd_o
);
  import qwt_pkg::*;

  logic skip_q, skip_d;
  logic sq_q, sq_d;
  logic dq_q, dq_d;
  logic esc_q, esc_d;
  logic has_result;
  logic plain;
  logic accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_result;

  // Classify the incoming byte against the lexer mode
  always_comb begin
    skip_d         = skip_q;
    sq_d           = sq_q;
    dq_d           = dq_q;
    esc_d          = esc_q;
    has_result     = 1'b0;
    plain          = 1'b0;
    cmd_o.data     = in_byte_i;
    cmd_o.kind     = KIND_BYTE;
    cmd_o.esc_pair = 1'b0;

    if (in_byte_i == ChNul) begin
      // string end: abandon quotes and any pending escape
      has_result = 1'b1;
      cmd_o.data = ChNul;
      cmd_o.kind = KIND_END;
      skip_d     = 1'b1;
      sq_d       = 1'b0;
      dq_d       = 1'b0;
      esc_d      = 1'b0;
    end else if (skip_q && is_blank(in_byte_i)) begin
      // leading blank, nothing to do
    end else begin
      skip_d = 1'b0;
      if (esc_q) begin
        esc_d = 1'b0;
        if (sq_q) begin
          plain = (in_byte_i == ChBslash) || (in_byte_i == ChSquote);
        end else if (dq_q) begin
          plain = (in_byte_i == ChBslash) || (in_byte_i == ChDquote);
        end else begin
          plain = (in_byte_i == ChBslash) || (in_byte_i == ChSquote) ||
                  (in_byte_i == ChDquote) || is_blank(in_byte_i);
        end
        has_result     = 1'b1;
        cmd_o.esc_pair = !plain;
      end else if (in_byte_i == ChBslash) begin
        esc_d = 1'b1;
      end else if (sq_q) begin
        if (in_byte_i == ChSquote) sq_d = 1'b0;
        else                       has_result = 1'b1;
      end else if (dq_q) begin
        if (in_byte_i == ChDquote) dq_d = 1'b0;
        else                       has_result = 1'b1;
      end else if (in_byte_i == ChSquote) begin
        sq_d = 1'b1;
      end else if (in_byte_i == ChDquote) begin
        dq_d = 1'b1;
      end else if (is_blank(in_byte_i) || (in_byte_i == ChSemi)) begin
        // unquoted delimiter ends the word
        has_result = 1'b1;
        cmd_o.data = ChNul;
        cmd_o.kind = is_blank(in_byte_i) ? KIND_BLANK : KIND_SEMI;
        skip_d     = 1'b1;
        sq_d       = 1'b0;
        dq_d       = 1'b0;
      end else begin
        has_result = 1'b1;
      end
    end
  end

  // Mode registers advance on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b1;
      sq_q   <= 1'b0;
      dq_q   <= 1'b0;
      esc_q  <= 1'b0;
    end else if (accept) begin
      skip_q <= skip_d;
      sq_q   <= sq_d;
      dq_q   <= dq_d;
      esc_q  <= esc_d;
    end
  end

endmodule

@@ sv/qwt_fifo.sv @@
module qwt_fifo #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qwt_pkg::qwt_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output qwt_pkg::qwt_cmd_t head_o
);
  import qwt_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthC  = CW'(Depth);

  qwt_cmd_t      mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ sv/qwt_back.sv @@
module qwt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  qwt_pkg::qwt_cmd_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        kind_o,
  output logic              last_of_run_o
);
  import qwt_pkg::*;

  logic       valid_q;
  logic       second_q;  // backslash already sent, escaped byte still due
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       last_q;
  logic       load;

  assign load          = !valid_q || out_ready_i;
  assign pop_o         = load && !q_empty_i && (second_q || !head_i.esc_pair);
  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign kind_o        = kind_q;
  assign last_of_run_o = last_q;

  // Control: output valid and escape-pair phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      valid_q <= !q_empty_i;
      if (!q_empty_i) second_q <= !second_q && head_i.esc_pair;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load && !q_empty_i) begin
      if (second_q || !head_i.esc_pair) begin
        byte_q <= head_i.data;
        kind_q <= head_i.kind;
        last_q <= 1'b1;
      end else begin
        byte_q <= ChBslash;
        kind_q <= KIND_BYTE;
        last_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // The escaped byte's command stays queued until its second result is loaded into the output register
  a_second_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !q_empty_i)
    else $error("escape pair pending with empty queue");

  // A non-final result is always the kept backslash
  a_first_is_bslash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q) |-> (byte_q == ChBslash && kind_q == KIND_BYTE))
    else $error("non-final result is not a kept backslash");

  // End markers carry a zero byte
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != KIND_BYTE) |-> (byte_q == ChNul && last_q))
    else $error("end marker with nonzero byte or not last");
`endif

endmodule

@@ sv/quoted_word_tokenizer_core.sv @@
// Shell-style quoted word lexer. Takes one byte per transaction on the in
// channel and delivers word bytes and end markers on the out channel. A
// classifier front end tracks blank skipping, quote modes and escapes and
// accepts a byte every cycle while its command queue (FifoDepth entries)
// has room; an emitter drains the queue into a registered output at one
// result per cycle while the receiver is ready. An escape that keeps its
// backslash yields two results, the backslash and then the escaped byte.
// Delimiters (unquoted blank, semicolon, zero byte) are consumed and send
// one end marker with last_of_run set, then the lexer returns to its start
// state. Reset state: skipping blanks, no quote, no escape pending.
module quoted_word_tokenizer_core #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_of_run_o
);
  import qwt_pkg::*;

  logic     q_full, q_empty, push, pop;
  qwt_cmd_t push_cmd, head_cmd;

  qwt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  qwt_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  qwt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ test/quoted_word_tokenizer_core_test.sv @@
module quoted_word_tokenizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qwt_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int SettleDelay = 12;   // queue depth plus output stage, with margin

  // One expected result on the out channel
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } token_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic       last_of_run_o;

  quoted_word_tokenizer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .last_of_run_o(last_of_run_o)
  );

  // Lexer state mirror
  logic skip_blank;
  logic in_squote;
  logic in_dquote;
  logic esc_pend;

  token_t expected_tokens[$];

  int idle_pct;
  int stall_pct;
  int cycle_count;
  int bytes_sent;
  int tokens_checked;
  int mismatch_count;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[quoted_word_tokenizer_core] ERROR");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic is_white(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09 : 8'h0D]});
  endfunction

  task automatic push_token(input logic [7:0] data, input kind_e kind, input logic last);
    token_t t;
    t.data = data;
    t.kind = kind;
    t.last = last;
    expected_tokens.push_back(t);
  endtask

  // Delimiter: one end marker, back to the start state
  task automatic end_word(input kind_e kind);
    push_token(ChNul, kind, 1'b1);
    skip_blank = 1'b1;
    in_squote  = 1'b0;
    in_dquote  = 1'b0;
    esc_pend   = 1'b0;
  endtask

  // Advance the lexer mirror by one byte and queue what it emits
  task automatic predict_tokens(input logic [7:0] c);
    logic literal;
    if (c == ChNul) begin
      end_word(KIND_END);
      return;
    end
    if (skip_blank) begin
      if (is_white(c)) return;
      skip_blank = 1'b0;
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (in_squote) literal = (c == ChBslash) || (c == ChSquote);
      else if (in_dquote) literal = (c == ChBslash) || (c == ChDquote);
      else literal = (c == ChBslash) || (c == ChSquote) || (c == ChDquote) || is_white(c);
      // escape with no meaning here keeps its backslash
      if (!literal) push_token(ChBslash, KIND_BYTE, 1'b0);
      push_token(c, KIND_BYTE, 1'b1);
    end else if (c == ChBslash) begin
      esc_pend = 1'b1;
    end else if (in_squote) begin
      if (c == ChSquote) in_squote = 1'b0;
      else push_token(c, KIND_BYTE, 1'b1);
    end else if (in_dquote) begin
      if (c == ChDquote) in_dquote = 1'b0;
      else push_token(c, KIND_BYTE, 1'b1);
    end else if (c == ChSquote) begin
      in_squote = 1'b1;
    end else if (c == ChDquote) begin
      in_dquote = 1'b1;
    end else if (is_white(c)) begin
      end_word(KIND_BLANK);
    end else if (c == ChSemi) begin
      end_word(KIND_SEMI);
    end else begin
      push_token(c, KIND_BYTE, 1'b1);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: out_byte %0h kind %0d last_of_run %0b",
               out_byte_o, kind_o, last_of_run_o);
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte_o);
          mismatch_count++;
        end
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  // Send one byte; valid stays high into the next call unless the sender idles
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tokens(c);
    bytes_sent++;
  endtask

  // Stop sending and let every expected result drain
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  // Byte mix biased toward words, quotes and escapes
  function automatic logic [7:0] pick_lex_byte();
    int r;
    r = $urandom_range(99);
    if (r < 38) return 8'($urandom_range(8'h7E, 8'h21));
    if (r < 48) return (r < 43) ? 8'h20 : 8'(8'h09 + $urandom_range(4));
    if (r < 55) return ChSemi;
    if (r < 63) return ChSquote;
    if (r < 71) return ChDquote;
    if (r < 82) return ChBslash;
    if (r < 85) return ChNul;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_random_bytes(input int count, input logic pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_tokens();
      send_byte(pick_lex_byte());
    end
    drain_tokens();
  endtask

  // Field extremes, every mode and the corner cases
  task automatic test_directed_cases();
    logic [7:0] seq [] = '{
      8'h20, 8'h09, ChSemi,                      // blanks skipped, empty word at semicolon
      8'hFF, 8'h01, 8'h0D,                       // extreme bytes, end at blank
      ChSquote, 8'h20, ChBslash, 8'h41, ChSquote, // quoted blank, kept backslash in single quotes
      ChDquote, ChBslash, ChDquote, ChSemi,      // escaped quote, quoted semicolon
      ChBslash, 8'h80, ChNul,                    // kept backslash in double quotes, end inside quote
      ChBslash, ChSemi, ChBslash, 8'h0A,         // escapes outside quotes
      ChBslash, ChNul,                           // escape dropped at string end
      ChNul                                      // empty word at string end
    };
    idle_pct  = 0;
    stall_pct = 0;
    foreach (seq[i]) send_byte(seq[i]);
    drain_tokens();
  endtask

  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    run_random_bytes(120, 1'b0);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 68;
    stall_pct = 0;
    run_random_bytes(120, 1'b1);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 68;
    run_random_bytes(120, 1'b0);
  endtask

  task automatic test_mixed_gaps();
    idle_pct  = 18;
    stall_pct = 18;
    run_random_bytes(120, 1'b0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    out_ready_i    = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    cycle_count    = 0;
    bytes_sent     = 0;
    tokens_checked = 0;
    mismatch_count = 0;
    skip_blank     = 1'b1;
    in_squote      = 1'b0;
    in_dquote      = 1'b0;
    esc_pend       = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();

    $display("Lexed %0d bytes (corner cases, then random words under gaps and stalls);",
             bytes_sent);
    $display("%0d results compared, %0d mismatches.", tokens_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[quoted_word_tokenizer_core] OK");
    end else begin
      $display("[quoted_word_tokenizer_core] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/qwt_pkg.sv
sv/qwt_front.sv
sv/qwt_fifo.sv
sv/qwt_back.sv
sv/quoted_word_tokenizer_core.sv
test/quoted_word_tokenizer_core_test.sv
